/* rtl/core/kml_pkg.sv */
// Package for the 2D k-means engine: item structs, function codes, status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kml_pkg;
  localparam int CoordBits = 16;
  localparam int IndexBits = 12;
  localparam int InertiaBits = 45;

  localparam logic [2:0] FUNC_ADD   = 3'd0;
  localparam logic [2:0] FUNC_SETC  = 3'd1;
  localparam logic [2:0] FUNC_RUN   = 3'd2;
  localparam logic [2:0] FUNC_READP = 3'd3;
  localparam logic [2:0] FUNC_READC = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic REG_K_USED = 1'b0;
  localparam logic REG_MAX_ITER = 1'b1;

  typedef struct packed {
    logic [2:0]                  func;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic [IndexBits-1:0]        index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [CoordBits-1:0] value_x;
    logic signed [CoordBits-1:0] value_y;
    logic [7:0]                  label;
    logic                        label_valid;
    logic [9:0]                  iterations_done;
    logic                        converged;
    logic [InertiaBits-1:0]      inertia;
  } rsp_t;
endpackage
`default_nettype wire

/* rtl/core/kml_div.sv */
// Serial signed divider: truncating quotient of a sum by a positive count.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module kml_div #(
  parameter int NUM_BITS = 29,
  parameter int DEN_BITS = 13
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic signed [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0]        den,
  output logic                            done,
  output logic signed [NUM_BITS-1:0]      quo
);
  localparam int CntBits = $clog2(NUM_BITS + 1);
  logic [NUM_BITS-1:0] rem_q, quo_q;
  logic [DEN_BITS:0]   part;
  logic [DEN_BITS-1:0] den_q;
  logic                neg, run;
  logic [CntBits-1:0]  cnt;
  logic [DEN_BITS:0]   trial;

  always_comb begin
    trial = {part[DEN_BITS-1:0], rem_q[NUM_BITS-1]};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (go) begin
      run   <= 1'b1;
      neg   <= num[NUM_BITS-1];
      rem_q <= num[NUM_BITS-1] ? NUM_BITS'(-num) : num;
      den_q <= den;
      part  <= '0;
      cnt   <= CntBits'(NUM_BITS);
    end else if (run) begin
      // one quotient bit per cycle, restoring
      rem_q <= {rem_q[NUM_BITS-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        part  <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
      end else begin
        part  <= trial;
        quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = neg ? -$signed(quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

/* rtl/core/kmeans_lloyd_2d.sv */
// 2D k-means engine: the command is one item at a time. Loads, centroid writes, ignored
// codes and out-of-range reads go straight to S_RESP, which raises the result strobe;
// valid point and centroid reads pass S_RDWAIT and S_RDDATA (address, registered memory read, capture).
// A run's length is set by the single distance unit that steps the centroid memory one
// centroid at a time, and by the 29-bit serial divider shared by x and y, which runs once
// per coordinate of each non-empty cluster. busy is high while an item is in work;
// the result strobe cannot be held off.
// Depends on kml_pkg and kml_div.
`timescale 1ns / 1ps
`default_nettype none
module kmeans_lloyd_2d #(
  parameter int POINT_CAPACITY = 4096,
  parameter int CLUSTER_CAPACITY = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire kml_pkg::cmd_t cmd,
  output logic              busy,
  output logic              result_valid,
  output kml_pkg::rsp_t     result,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [9:0]   cfg_data
);
  import kml_pkg::*;

  localparam int PB = $clog2(POINT_CAPACITY);
  localparam int NB = PB + 1;
  localparam int CB = $clog2(CLUSTER_CAPACITY);
  localparam int KB = CB + 1;
  localparam int SB = CoordBits + NB;
  localparam int DB = 2 * CoordBits + 2;

  localparam logic [4:0] S_IDLE = 5'd0, S_RDWAIT = 5'd1, S_RESP = 5'd2,
    S_A_RD = 5'd3, S_A_CMP = 5'd4, S_A_WB = 5'd5, S_CLR = 5'd6,
    S_R_RD = 5'd7, S_R_ACC = 5'd8, S_R_WB = 5'd9, S_D_RD = 5'd10,
    S_D_X = 5'd11, S_D_Y = 5'd12, S_D_WB = 5'd13, S_I_RD = 5'd14,
    S_I_C = 5'd15, S_I_ACC = 5'd16, S_ROUND = 5'd17, S_A_PT = 5'd18,
    S_R_PT = 5'd19, S_I_PT = 5'd20, S_CVALID = 5'd21, S_RDDATA = 5'd22;

  logic [4:0] state;
  logic [8:0] k_used;
  logic [9:0] max_iter;
  logic [NB-1:0] points_loaded;
  cmd_t cmd_q;

  // memories
  logic [CoordBits-1:0] pmx [POINT_CAPACITY];
  logic [CoordBits-1:0] pmy [POINT_CAPACITY];
  logic [KB:0] plab [POINT_CAPACITY]; // {ok, label}
  logic [CoordBits-1:0] cmx [CLUSTER_CAPACITY];
  logic [CoordBits-1:0] cmy [CLUSTER_CAPACITY];
  logic [SB-1:0] asx [CLUSTER_CAPACITY];
  logic [SB-1:0] asy [CLUSTER_CAPACITY];
  logic [NB-1:0] acn [CLUSTER_CAPACITY];
  logic [CLUSTER_CAPACITY-1:0] cvalid; // centroid entry written since reset

  logic [PB-1:0] p_addr;
  logic [CB-1:0] c_addr;
  logic signed [CoordBits-1:0] p_x, p_y, c_x, c_y;
  logic [KB:0] p_l;
  logic [SB-1:0] a_x, a_y;
  logic [NB-1:0] a_n;
  logic c_ok;

  always_ff @(posedge clk) begin
    p_x <= pmx[p_addr];
    p_y <= pmy[p_addr];
    p_l <= plab[p_addr];
    c_x <= cmx[c_addr];
    c_y <= cmy[c_addr];
    c_ok <= cvalid[c_addr];
    a_x <= asx[c_addr];
    a_y <= asy[c_addr];
    a_n <= acn[c_addr];
  end

  logic signed [CoordBits-1:0] cx_v, cy_v;
  assign cx_v = c_ok ? c_x : '0;
  assign cy_v = c_ok ? c_y : '0;

  // iteration counters
  logic [NB-1:0] pi;
  logic [KB-1:0] ci;
  logic [KB-1:0] kk;
  logic [9:0] iter;
  logic changed;
  logic [DB-1:0] best_d;
  logic [KB-1:0] best_c;
  logic [InertiaBits-1:0] ine;
  logic [1:0] i_wait;

  // distance of current point to current centroid, registered squares
  logic signed [CoordBits:0] dx, dy;
  logic [DB-1:0] sqx, sqy, sq_sum;
  assign dx = {p_x[CoordBits-1], p_x} - {cx_v[CoordBits-1], cx_v};
  assign dy = {p_y[CoordBits-1], p_y} - {cy_v[CoordBits-1], cy_v};
  always_ff @(posedge clk) begin
    sqx <= $unsigned(DB'(dx) * DB'(dx));
    sqy <= $unsigned(DB'(dy) * DB'(dy));
  end
  assign sq_sum = sqx + sqy;

  // divider
  logic dv_go, dv_done;
  logic signed [SB-1:0] dv_num, dv_quo;
  logic signed [CoordBits-1:0] nx;
  logic u_div_busy;
  kml_div #(.NUM_BITS(SB), .DEN_BITS(NB)) u_div (
    .clk(clk), .rst(rst), .go(dv_go), .num(dv_num), .den(a_n),
    .done(dv_done), .quo(dv_quo));

  logic [InertiaBits:0] ine_sum;
  assign ine_sum = {1'b0, ine} + (InertiaBits+1)'(sq_sum);
  logic sq_ready;

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    dv_go <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      k_used <= 9'd1;
      max_iter <= 10'd100;
      points_loaded <= '0;
      cvalid <= '0;
      u_div_busy <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_K_USED) k_used <= cfg_data[8:0];
            else max_iter <= cfg_data;
          end
          if (start) begin
            cmd_q <= cmd;
            result <= '0;
            p_addr <= cmd.index[PB-1:0];
            c_addr <= cmd.index[CB-1:0];
            case (cmd.func)
              FUNC_ADD: begin
                if (points_loaded >= NB'(POINT_CAPACITY)) begin
                  result.status <= ST_FULL;
                end else begin
                  pmx[points_loaded[PB-1:0]] <= cmd.coord_x;
                  pmy[points_loaded[PB-1:0]] <= cmd.coord_y;
                  plab[points_loaded[PB-1:0]] <= '0;
                  points_loaded <= points_loaded + 1'b1;
                end
                state <= S_RESP;
              end
              FUNC_SETC: begin
                if (32'(cmd.index) >= CLUSTER_CAPACITY) begin
                  result.status <= ST_BAD;
                end else begin
                  cmx[cmd.index[CB-1:0]] <= cmd.coord_x;
                  cmy[cmd.index[CB-1:0]] <= cmd.coord_y;
                  cvalid[cmd.index[CB-1:0]] <= 1'b1;
                end
                state <= S_RESP;
              end
              FUNC_RUN: begin
                if (k_used == 9'd0) kk <= KB'(1);
                else if (32'(k_used) > CLUSTER_CAPACITY) kk <= KB'(CLUSTER_CAPACITY);
                else kk <= KB'(k_used);
                iter <= '0;
                ine <= '0;
                pi <= '0;
                if (max_iter == 10'd0) state <= S_I_PT;
                else state <= S_ROUND;
              end
              FUNC_READP: begin
                if (NB'(cmd.index) >= points_loaded ||
                    32'(cmd.index) >= POINT_CAPACITY) begin
                  result.status <= ST_BAD;
                  state <= S_RESP;
                end else state <= S_RDWAIT;
              end
              FUNC_READC: begin
                if (32'(cmd.index) >= CLUSTER_CAPACITY) begin
                  result.status <= ST_BAD;
                  state <= S_RESP;
                end else state <= S_RDWAIT;
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_RDWAIT: begin
          // memory read of the new address in flight
          state <= S_RDDATA;
        end
        S_RDDATA: begin
          if (cmd_q.func == FUNC_READP) begin
            result.value_x <= p_x;
            result.value_y <= p_y;
            result.label_valid <= p_l[KB];
            result.label <= p_l[KB] ? p_l[7:0] : 8'd0;
          end else begin
            result.value_x <= cx_v;
            result.value_y <= cy_v;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          result_valid <= 1'b1;
          state <= S_IDLE;
        end
        // ---- assignment round
        S_ROUND: begin
          changed <= 1'b0;
          pi <= '0;
          state <= S_A_PT;
        end
        S_A_PT: begin
          if (pi == points_loaded) begin
            ci <= '0;
            state <= S_CLR;
          end else begin
            p_addr <= pi[PB-1:0];
            c_addr <= '0;
            ci <= '0;
            sq_ready <= 1'b0;
            state <= S_A_RD;
          end
        end
        S_A_RD: begin
          // point and first centroid reads in flight
          state <= S_A_CMP;
          ci <= '0;
        end
        S_A_CMP: begin
          // square first, then compare, for each centroid in turn
          if (!sq_ready) begin
            sq_ready <= 1'b1;
            if (ci + 1'b1 < kk) c_addr <= CB'(ci + 1'b1);
          end else begin
            if (ci == '0 || sq_sum < best_d) begin
              best_d <= sq_sum;
              best_c <= ci;
            end
            sq_ready <= 1'b0;
            if (ci + 1'b1 == kk) state <= S_A_WB;
            else ci <= ci + 1'b1;
          end
        end
        S_A_WB: begin
          if (!p_l[KB] || p_l[KB-1:0] != best_c) begin
            plab[pi[PB-1:0]] <= {1'b1, best_c};
            changed <= 1'b1;
          end
          pi <= pi + 1'b1;
          state <= S_A_PT;
        end
        // ---- recompute round
        S_CLR: begin
          asx[ci[CB-1:0]] <= '0;
          asy[ci[CB-1:0]] <= '0;
          acn[ci[CB-1:0]] <= '0;
          if (ci + 1'b1 == kk) begin
            pi <= '0;
            state <= S_R_PT;
          end else ci <= ci + 1'b1;
        end
        S_R_PT: begin
          if (pi == points_loaded) begin
            ci <= '0;
            state <= S_D_RD;
            c_addr <= '0;
          end else begin
            p_addr <= pi[PB-1:0];
            state <= S_R_RD;
          end
        end
        S_R_RD: begin
          state <= S_CVALID;
        end
        S_CVALID: begin
          // label known; read its accumulators
          if (p_l[KB] && p_l[KB-1:0] < kk) begin
            c_addr <= p_l[CB-1:0];
            state <= S_R_ACC;
          end else begin
            pi <= pi + 1'b1;
            state <= S_R_PT;
          end
        end
        S_R_ACC: begin
          state <= S_R_WB;
        end
        S_R_WB: begin
          asx[c_addr] <= a_x + SB'($signed(p_x));
          asy[c_addr] <= a_y + SB'($signed(p_y));
          acn[c_addr] <= a_n + 1'b1;
          pi <= pi + 1'b1;
          state <= S_R_PT;
        end
        S_D_RD: begin
          state <= S_D_X;
          dv_go <= 1'b0;
        end
        S_D_X: begin
          if (a_n == '0) begin
            state <= S_D_WB;
          end else if (!dv_go && !u_div_busy) begin
            dv_num <= $signed(a_x);
            dv_go <= 1'b1;
            u_div_busy <= 1'b1;
          end else if (dv_done) begin
            nx <= dv_quo[CoordBits-1:0];
            dv_num <= $signed(a_y);
            dv_go <= 1'b1;
            state <= S_D_Y;
          end
        end
        S_D_Y: begin
          if (dv_done) begin
            u_div_busy <= 1'b0;
            if (nx != cx_v || dv_quo[CoordBits-1:0] != cy_v) changed <= 1'b1;
            cmx[c_addr] <= nx;
            cmy[c_addr] <= dv_quo[CoordBits-1:0];
            cvalid[c_addr] <= 1'b1;
            state <= S_D_WB;
          end
        end
        S_D_WB: begin
          if (ci + 1'b1 == kk) begin
            pi <= '0;
            // a quiet round ends the loop without counting
            if (!changed) state <= S_I_PT;
            else begin
              iter <= iter + 1'b1;
              if (iter + 1'b1 == max_iter) state <= S_I_PT;
              else state <= S_ROUND;
            end
          end else begin
            ci <= ci + 1'b1;
            c_addr <= CB'(ci + 1'b1);
            state <= S_D_RD;
          end
        end
        // ---- inertia
        S_I_PT: begin
          if (pi == points_loaded) begin
            result.iterations_done <= iter;
            result.converged <= (iter < max_iter);
            result.inertia <= ine;
            state <= S_RESP;
          end else begin
            p_addr <= pi[PB-1:0];
            state <= S_I_RD;
          end
        end
        S_I_RD: begin
          state <= S_I_C;
        end
        S_I_C: begin
          if (p_l[KB]) begin
            c_addr <= p_l[CB-1:0];
            i_wait <= 2'd2;
            state <= S_I_ACC;
          end else begin
            pi <= pi + 1'b1;
            state <= S_I_PT;
          end
        end
        S_I_ACC: begin
          // centroid read, then square, then add
          if (i_wait != 2'd0) i_wait <= i_wait - 1'b1;
          else begin
            ine <= ine_sum[InertiaBits] ? '1 : ine_sum[InertiaBits-1:0];
            pi <= pi + 1'b1;
            state <= S_I_PT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) result_valid |-> !busy);
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");
  assert property (@(posedge clk) disable iff (rst)
    !(cfg_valid && cfg_ready && start)) else $error("cfg during item");
  assert property (@(posedge clk) disable iff (rst)
    points_loaded <= NB'(POINT_CAPACITY)) else $error("point count overflow");
endmodule
`default_nettype wire

/* test/tb_kmeans_lloyd_2d.sv */
// Self-checking testbench for kmeans_lloyd_2d: queued command items, config writes,
// random gaps, and an in-bench k-means predictor compared field by field.
// Depends on kml_pkg and the kmeans_lloyd_2d RTL.
`timescale 1ns / 1ps
module tb_kmeans_lloyd_2d;
  import kml_pkg::*;

  localparam int NPts = 4096;
  localparam int NClus = 256;
  localparam longint InertiaMax = (64'd1 << 45) - 1;
  localparam int CycleLimit = 40000000;

  typedef enum logic [1:0] {OP_CMD, OP_CFG, OP_DRAIN} op_kind_t;
  typedef struct {
    op_kind_t    kind;
    cmd_t        c;
    logic        ci;
    logic [9:0]  cd;
  } op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy, result_valid, cfg_ready;
  rsp_t result;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [9:0] cfg_data = '0;

  kmeans_lloyd_2d u_dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  longint pt_x[NPts], pt_y[NPts], cen_x[NClus], cen_y[NClus];
  int pt_lab[NPts];
  bit pt_assigned[NPts];
  int pts_loaded = 0;
  int k_reg = 1;
  int iter_reg = 100;

  op_t item_q[$];
  rsp_t expected_rsp[$];
  int errors = 0;
  int gap = 0;
  int settle = 0;
  logic cmd_acc = 1'b0, cfg_acc = 1'b0;
  int cycles = 0;

  function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  function automatic bit assign_pass(int k);
    bit changed;
    int best;
    longint bd, d;
    changed = 0;
    for (int p = 0; p < pts_loaded; p++) begin
      best = 0;
      bd = sq_dist(pt_x[p], pt_y[p], cen_x[0], cen_y[0]);
      for (int c = 1; c < k; c++) begin
        d = sq_dist(pt_x[p], pt_y[p], cen_x[c], cen_y[c]);
        if (d < bd) begin
          bd = d;
          best = c;
        end
      end
      if (!pt_assigned[p] || pt_lab[p] != best) begin
        pt_lab[p] = best;
        pt_assigned[p] = 1;
        changed = 1;
      end
    end
    return changed;
  endfunction

  function automatic bit recompute_pass(int k);
    longint sx[NClus], sy[NClus], nx, ny;
    int cnt[NClus];
    bit changed;
    changed = 0;
    for (int c = 0; c < k; c++) begin
      sx[c] = 0;
      sy[c] = 0;
      cnt[c] = 0;
    end
    for (int p = 0; p < pts_loaded; p++) begin
      if (pt_assigned[p] && pt_lab[p] < k) begin
        sx[pt_lab[p]] += pt_x[p];
        sy[pt_lab[p]] += pt_y[p];
        cnt[pt_lab[p]]++;
      end
    end
    for (int c = 0; c < k; c++) begin
      if (cnt[c] > 0) begin
        nx = sx[c] / cnt[c];  // truncates toward zero
        ny = sy[c] / cnt[c];
        if (nx != cen_x[c] || ny != cen_y[c]) changed = 1;
        cen_x[c] = nx;
        cen_y[c] = ny;
      end
    end
    return changed;
  endfunction

  function automatic rsp_t predict_response(cmd_t c);
    rsp_t r;
    int k, n, idx;
    bit stop, a, b;
    longint acc, d;
    r = '0;
    idx = int'(c.index);
    case (c.func)
      FUNC_ADD: begin
        if (pts_loaded >= NPts) r.status = ST_FULL;
        else begin
          pt_x[pts_loaded] = longint'(c.coord_x);
          pt_y[pts_loaded] = longint'(c.coord_y);
          pt_assigned[pts_loaded] = 0;
          pt_lab[pts_loaded] = 0;
          pts_loaded++;
        end
      end
      FUNC_SETC: begin
        if (idx >= NClus) r.status = ST_BAD;
        else begin
          cen_x[idx] = longint'(c.coord_x);
          cen_y[idx] = longint'(c.coord_y);
        end
      end
      FUNC_RUN: begin
        k = (k_reg == 0) ? 1 : (k_reg > NClus ? NClus : k_reg);
        n = 0;
        stop = 0;
        while (n < iter_reg && !stop) begin
          a = assign_pass(k);
          b = recompute_pass(k);
          if (!a && !b) stop = 1;
          else n++;
        end
        r.iterations_done = n[9:0];
        r.converged = (n < iter_reg);
        acc = 0;
        for (int p = 0; p < pts_loaded; p++) begin
          if (pt_assigned[p]) begin
            d = sq_dist(pt_x[p], pt_y[p], cen_x[pt_lab[p]], cen_y[pt_lab[p]]);
            acc = (d > InertiaMax - acc) ? InertiaMax : acc + d;
          end
        end
        r.inertia = acc[44:0];
      end
      FUNC_READP: begin
        if (idx >= pts_loaded) r.status = ST_BAD;
        else begin
          r.value_x = pt_x[idx][15:0];
          r.value_y = pt_y[idx][15:0];
          if (pt_assigned[idx]) begin
            r.label = pt_lab[idx][7:0];
            r.label_valid = 1'b1;
          end
        end
      end
      FUNC_READC: begin
        if (idx >= NClus) r.status = ST_BAD;
        else begin
          r.value_x = cen_x[idx][15:0];
          r.value_y = cen_y[idx][15:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void report(string name, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endfunction

  // monitor and predictor
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (result_valid) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t unexpected result: actual %0h", $time, result);
          errors++;
        end else begin
          e = expected_rsp.pop_front();
          report("status", 64'(e.status), 64'(result.status));
          report("value_x", 64'(e.value_x), 64'(result.value_x));
          report("value_y", 64'(e.value_y), 64'(result.value_y));
          report("label", 64'(e.label), 64'(result.label));
          report("label_valid", 64'(e.label_valid), 64'(result.label_valid));
          report("iterations_done", 64'(e.iterations_done),
                 64'(result.iterations_done));
          report("converged", 64'(e.converged), 64'(result.converged));
          report("inertia", 64'(e.inertia), 64'(result.inertia));
        end
      end
      if (start && !busy) expected_rsp = {expected_rsp, predict_response(cmd)};
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_K_USED) k_reg = int'(cfg_data[8:0]);
        else iter_reg = int'(cfg_data);
      end
      cmd_acc <= start && !busy;
      cfg_acc <= cfg_valid && cfg_ready;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(negedge clk) begin
    logic ns, nv;
    op_t o;
    if (!rst) begin
      ns = start;
      nv = cfg_valid;
      if (start && cmd_acc) ns = 1'b0;
      if (cfg_valid && cfg_acc) nv = 1'b0;
      if (!ns && !nv) begin
        if (gap > 0) gap--;
        else if (item_q.size() > 0) begin
          o = item_q[0];
          case (o.kind)
            OP_CMD: begin
              cmd <= o.c;
              ns = 1'b1;
              void'(item_q.pop_front());
              gap = pick_gap();
            end
            OP_CFG: begin
              cfg_index <= o.ci;
              cfg_data <= o.cd;
              nv = 1'b1;
              void'(item_q.pop_front());
            end
            OP_DRAIN: begin
              // hold off until the block is idle, then let it settle
              if (expected_rsp.size() != 0 || busy || start) settle = 4;
              else if (settle > 0) settle--;
              else void'(item_q.pop_front());
            end
            default: ;
          endcase
        end
      end
      start <= ns;
      cfg_valid <= nv;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus
  int planned_pts = 0;
  int hub_x[4], hub_y[4];

  task automatic push_cmd(logic [2:0] f, logic [15:0] x, logic [15:0] y, logic [11:0] idx);
    op_t o;
    o.kind = OP_CMD;
    o.c.func = f;
    o.c.coord_x = x;
    o.c.coord_y = y;
    o.c.index = idx;
    o.ci = 0;
    o.cd = 0;
    item_q = {item_q, o};
    if (f == FUNC_ADD) planned_pts++;
  endtask

  task automatic push_cfg(logic i, logic [9:0] d);
    op_t o;
    o.kind = OP_DRAIN;
    o.c = '0;
    o.ci = 0;
    o.cd = 0;
    item_q = {item_q, o};
    o.kind = OP_CFG;
    o.ci = i;
    o.cd = d;
    item_q = {item_q, o};
  endtask

  function automatic logic [15:0] rand_coord(int axis_hub);
    int v;
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    v = axis_hub + $signed($urandom_range(0, 4000)) - 2000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  initial begin
    int h, r, f;
    for (int i = 0; i < 4; i++) begin
      hub_x[i] = $signed($urandom_range(0, 60000)) - 30000;
      hub_y[i] = $signed($urandom_range(0, 60000)) - 30000;
    end
    // directed part
    push_cmd(FUNC_RUN, 0, 0, 0);          // empty store
    push_cmd(FUNC_READP, 0, 0, 0);        // no points yet
    push_cmd(FUNC_READC, 0, 0, 255);
    push_cmd(FUNC_READC, 0, 0, 256);
    push_cmd(FUNC_SETC, 16'h1234, 16'h4321, 12'hFFF);
    push_cmd(3'd5, 16'hFFFF, 16'hFFFF, 12'hFFF);
    push_cmd(3'd6, 0, 0, 0);
    push_cmd(3'd7, 0, 0, 0);
    push_cmd(FUNC_ADD, 16'h8000, 16'h8000, 0);
    push_cmd(FUNC_ADD, 16'h7FFF, 16'h7FFF, 0);
    push_cmd(FUNC_ADD, 16'h0000, 16'h0000, 0);
    push_cmd(FUNC_ADD, 16'hFFFF, 16'h0001, 0);
    push_cmd(FUNC_SETC, 16'h8000, 16'h7FFF, 0);
    push_cmd(FUNC_SETC, 16'h7FFF, 16'h8000, 255);
    push_cmd(FUNC_READP, 0, 0, 0);        // unassigned label
    push_cmd(FUNC_RUN, 0, 0, 0);
    push_cmd(FUNC_READP, 0, 0, 3);
    push_cmd(FUNC_READC, 0, 0, 0);
    push_cmd(FUNC_READP, 0, 0, 4);
    push_cfg(REG_K_USED, 10'd0);          // zero k acts as one
    push_cfg(REG_MAX_ITER, 10'd0);        // zero rounds
    push_cmd(FUNC_RUN, 0, 0, 0);
    push_cfg(REG_K_USED, 10'd511);        // clamps to capacity
    push_cfg(REG_MAX_ITER, 10'd1);
    push_cmd(FUNC_RUN, 0, 0, 0);
    push_cmd(FUNC_READP, 0, 0, 1);
    push_cmd(FUNC_READC, 0, 0, 255);
    push_cfg(REG_K_USED, 10'd1);          // stale labels above k, zero rounds
    push_cfg(REG_MAX_ITER, 10'd0);
    push_cmd(FUNC_RUN, 0, 0, 0);
    push_cfg(REG_K_USED, 10'd256);
    push_cfg(REG_MAX_ITER, 10'd1023);
    push_cmd(FUNC_RUN, 0, 0, 0);
    push_cmd(FUNC_READP, 0, 0, 2);
    // random part
    for (int n = 0; n < 715; n++) begin
      if (n % 120 == 0) begin
        r = $urandom_range(0, 9);
        push_cfg(REG_K_USED, r == 0 ? 10'($urandom_range(9, 20)) : 10'($urandom_range(1, 8)));
        r = $urandom_range(0, 9);
        push_cfg(REG_MAX_ITER, r == 0 ? 10'd0 : 10'($urandom_range(1, 40)));
      end
      h = $urandom_range(0, 3);
      f = $urandom_range(0, 99);
      if (f < 20 && planned_pts < 60)
        push_cmd(FUNC_ADD, rand_coord(hub_x[h]), rand_coord(hub_y[h]), 12'($urandom()));
      else if (f < 40)
        push_cmd(FUNC_SETC, rand_coord(hub_x[h]), rand_coord(hub_y[h]),
                 $urandom_range(0, 1) ? 12'($urandom_range(0, 15)) : 12'($urandom()));
      else if (f < 46)
        push_cmd(FUNC_RUN, 16'($urandom()), 16'($urandom()), 12'($urandom()));
      else if (f < 71)
        push_cmd(FUNC_READP, 16'($urandom()), 16'($urandom()),
                 $urandom_range(0, 3) != 0 ? 12'($urandom_range(0, 63)) : 12'($urandom()));
      else if (f < 91)
        push_cmd(FUNC_READC, 16'($urandom()), 16'($urandom()),
                 $urandom_range(0, 1) ? 12'($urandom_range(0, 20)) : 12'($urandom()));
      else
        push_cmd(3'($urandom_range(5, 7)), 16'($urandom()), 16'($urandom()),
                 12'($urandom()));
    end

    repeat (6) @(negedge clk);
    rst = 1'b0;
    wait (item_q.size() == 0 && !start && !cfg_valid && expected_rsp.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
